// ----- rtl/gp_port_pwm_fade_and_edge_monitor_core_defines.svh -----
// Assertion macros for the GP port PWM fade and edge monitor core.
// Included by the top level; no other dependencies.
`ifndef GP_PORT_PWM_FADE_AND_EDGE_MONITOR_CORE_DEFINES_SVH
`define GP_PORT_PWM_FADE_AND_EDGE_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define GPFEM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpfem assertion failed");

// Next-cycle implication, disabled in reset
`define GPFEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpfem assertion failed");

`endif

// ----- rtl/gpfem_pkg.sv -----
// Shared types and constants for the GP port PWM fade and edge monitor core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpfem_pkg;

   localparam int NUM_PORTS   = 3;
   localparam int SLOW_PERIOD = 10;
   localparam int SLOW_W      = 4;
   localparam int DUTY_W      = 8;
   localparam int FADE_W      = 8;
   localparam int CONF_W      = 4;
   localparam int ADC_W       = 10;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 64;

   typedef enum logic [1:0] {
      MODE_IN  = 2'd0,
      MODE_OUT = 2'd1,
      MODE_PWM = 2'd2,
      MODE_ADC = 2'd3
   } gpfem_mode_type;

   typedef enum logic [1:0] {
      PH_CHECK = 2'd0,
      PH_ADC   = 2'd1,
      PH_RISE  = 2'd2,
      PH_FALL  = 2'd3
   } gpfem_phase_type;

   typedef enum logic [1:0] {
      CSR_PORT1 = 2'd0,
      CSR_PORT2 = 2'd1,
      CSR_PORT3 = 2'd2,
      CSR_FADE  = 2'd3
   } gpfem_csr_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } gpfem_op_type;

   // Per-port control for one item
   typedef struct packed {
      logic              step;
      logic              is_write;
      logic              wr_hit;
      logic [DUTY_W-1:0] wr_value;
      logic              fade_off;
      logic              fade_step;
      logic              slow_pass;
      logic              cfg_clear;
   } gpfem_ctl_type;

   // Per-port status after the item
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [DUTY_W-1:0] value;
      logic              out_bit;
      logic              busy;
      logic              rise;
      logic              fall;
      logic              irq;
   } gpfem_stat_type;

endpackage

`default_nettype wire

// ----- rtl/gp_port_pwm_fade_and_edge_monitor_core.sv -----
// A transfer accepted on req_ passes the input register, then the result register, before it
// appears on rsp_. Throughput: one item per cycle while rsp_tready takes the results;
// a stalled result still lets one more item wait in the input register.
// Reset (synchronous): config, port state, counters and both valid bits cleared.
// Depends on gpfem_pkg, gpfem_port and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "gp_port_pwm_fade_and_edge_monitor_core_defines.svh"

module gp_port_pwm_fade_and_edge_monitor_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [1:0] port_select, [9:2] write_value, [12:10] pin_levels,
   // [22:13] adc_sample1, [32:23] adc_sample2, [42:33] adc_sample3
   input  wire logic [gpfem_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] pwm_duty1, [15:8] pwm_duty2, [23:16] pwm_duty3, [26:24] out_levels,
   // [34:27] value1, [42:35] value2, [50:43] value3, [53:51] fading_flags,
   // [59:54] edge_events, [60] irq_pulse
   output logic [gpfem_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [gpfem_pkg::FADE_W-1:0]       csr_wdata
);

   localparam int NP = gpfem_pkg::NUM_PORTS;

   logic                              in_valid_ff, in_valid_in;
   logic                              in_op_ff;
   logic [gpfem_pkg::REQ_DATA_W-1:0]  in_data_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [gpfem_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic [gpfem_pkg::CONF_W-1:0]      conf_ff [NP];
   logic [gpfem_pkg::FADE_W-1:0]      fade_period_ff;
   logic [gpfem_pkg::FADE_W-1:0]      fade_count_ff, fade_count_in;
   logic [gpfem_pkg::SLOW_W-1:0]      slow_count_ff, slow_count_in;
   logic                              advance, accept, tick;
   logic                              fade_step, slow_pass;
   logic [1:0]                        sel;
   logic [gpfem_pkg::DUTY_W-1:0]      wr_value;
   logic [NP-1:0]                     pins;
   gpfem_pkg::gpfem_stat_type         stat [NP];
   logic [2*NP-1:0]                   events;
   logic                              irq;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign sel      = in_data_ff[1:0];
   assign wr_value = in_data_ff[9:2];
   assign pins     = in_data_ff[12:10];
   assign tick     = (in_op_ff == gpfem_pkg::OP_TICK);

   assign fade_step = tick && (fade_period_ff != '0) && (fade_count_ff >= fade_period_ff);
   assign slow_pass = tick && (slow_count_ff > gpfem_pkg::SLOW_W'(gpfem_pkg::SLOW_PERIOD));

   always_comb begin
      fade_count_in = fade_count_ff;
      slow_count_in = slow_count_ff;
      if (advance && tick) begin
         if (fade_period_ff != '0) begin
            fade_count_in = fade_step ? '0 : fade_count_ff + 1'b1;
         end
         slow_count_in = slow_pass ? '0 : slow_count_ff + 1'b1;
      end
   end

   for (genvar k = 0; k < NP; k++) begin : g_port
      gpfem_pkg::gpfem_ctl_type ctl;

      assign ctl.step      = advance;
      assign ctl.is_write  = !tick;
      assign ctl.wr_hit    = (sel == 2'(k));
      assign ctl.wr_value  = wr_value;
      assign ctl.fade_off  = (fade_period_ff == '0);
      assign ctl.fade_step = fade_step;
      assign ctl.slow_pass = slow_pass;
      assign ctl.cfg_clear = csr_we && (csr_index == 2'(k));

      gpfem_port u_port (
         .clock (clock),
         .reset (reset),
         .conf  (conf_ff[k]),
         .ctl   (ctl),
         .pin   (pins[k]),
         .adc   (in_data_ff[13 + k*gpfem_pkg::ADC_W +: gpfem_pkg::ADC_W]),
         .stat  (stat[k])
      );

      assign events[2*k]   = stat[k].rise;
      assign events[2*k+1] = stat[k].fall;
   end

   assign irq = stat[0].irq | stat[1].irq | stat[2].irq;

   always_comb begin
      out_data_in = {
         3'b000,
         irq,
         events,
         stat[2].busy, stat[1].busy, stat[0].busy,
         stat[2].value, stat[1].value, stat[0].value,
         stat[2].out_bit, stat[1].out_bit, stat[0].out_bit,
         stat[2].duty, stat[1].duty, stat[0].duty
      };
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         fade_count_ff  <= '0;
         slow_count_ff  <= '0;
         fade_period_ff <= '0;
         for (int i = 0; i < NP; i++) begin
            conf_ff[i] <= '0;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         fade_count_ff <= fade_count_in;
         slow_count_ff <= slow_count_in;
         if (csr_we) begin
            case (gpfem_pkg::gpfem_csr_type'(csr_index))
               gpfem_pkg::CSR_PORT1: conf_ff[0] <= csr_wdata[gpfem_pkg::CONF_W-1:0];
               gpfem_pkg::CSR_PORT2: conf_ff[1] <= csr_wdata[gpfem_pkg::CONF_W-1:0];
               gpfem_pkg::CSR_PORT3: conf_ff[2] <= csr_wdata[gpfem_pkg::CONF_W-1:0];
               gpfem_pkg::CSR_FADE:  fade_period_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   `GPFEM_ASSERT_IMPL(a_irq_needs_event, clock, reset,
      rsp_tvalid && rsp_tdata[60], rsp_tdata[59:54] != 6'd0)
   `GPFEM_ASSERT_IMPL(a_no_rise_and_fall, clock, reset,
      advance, (events & (events >> 1) & 6'b010101) == 6'd0)
   `GPFEM_ASSERT_IMPL(a_slow_count_bound, clock, reset,
      1'b1, slow_count_ff <= gpfem_pkg::SLOW_W'(gpfem_pkg::SLOW_PERIOD + 1))
   `GPFEM_ASSERT_NEXT(a_write_no_events, clock, reset,
      advance && !tick, rsp_tdata[60:54] == 7'd0)

endmodule

`default_nettype wire

// ----- rtl/gpfem_port.sv -----
// One port: duty, value, phase, output and fade-busy state with next-state logic.
// Depends on gpfem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpfem_port (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [gpfem_pkg::CONF_W-1:0]   conf,
   input  wire gpfem_pkg::gpfem_ctl_type       ctl,
   input  wire logic                           pin,
   input  wire logic [gpfem_pkg::ADC_W-1:0]    adc,
   output gpfem_pkg::gpfem_stat_type           stat
);

   logic [gpfem_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic [gpfem_pkg::DUTY_W-1:0] value_ff, value_in;
   gpfem_pkg::gpfem_phase_type   phase_ff, phase_in;
   logic                         out_ff, out_in;
   logic                         busy_ff, busy_in;
   gpfem_pkg::gpfem_mode_type    mode;
   logic                         rise_evt, fall_evt, irq_evt;

   assign mode = gpfem_pkg::gpfem_mode_type'(conf[1:0]);

   always_comb begin
      duty_in  = duty_ff;
      value_in = value_ff;
      phase_in = phase_ff;
      out_in   = out_ff;
      busy_in  = busy_ff;
      rise_evt = 1'b0;
      fall_evt = 1'b0;
      irq_evt  = 1'b0;
      if (ctl.step) begin
         if (ctl.is_write) begin
            if (ctl.wr_hit) begin
               value_in = ctl.wr_value;
               case (mode)
                  gpfem_pkg::MODE_OUT: begin
                     if (ctl.wr_value == '0) begin
                        out_in = 1'b0;
                     end else begin
                        value_in = gpfem_pkg::DUTY_W'(1);
                        out_in   = 1'b1;
                     end
                  end
                  gpfem_pkg::MODE_PWM: begin
                     if (ctl.fade_off) begin
                        duty_in = ctl.wr_value;
                        busy_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            if (ctl.fade_step && mode == gpfem_pkg::MODE_PWM && duty_ff != value_ff) begin
               duty_in = (duty_ff < value_ff) ? duty_ff + 1'b1 : duty_ff - 1'b1;
               busy_in = (duty_in != value_ff);
            end
            if (ctl.slow_pass) begin
               case (phase_ff)
                  gpfem_pkg::PH_CHECK: begin
                     if (mode == gpfem_pkg::MODE_ADC) begin
                        phase_in = gpfem_pkg::PH_ADC;
                     end else if (mode == gpfem_pkg::MODE_IN) begin
                        phase_in = gpfem_pkg::PH_RISE;
                     end
                  end
                  gpfem_pkg::PH_ADC: begin
                     value_in = adc[gpfem_pkg::ADC_W-1:2];
                  end
                  gpfem_pkg::PH_RISE: begin
                     if (pin) begin
                        value_in = gpfem_pkg::DUTY_W'(1);
                        rise_evt = 1'b1;
                        irq_evt  = conf[2];
                        phase_in = gpfem_pkg::PH_FALL;
                     end
                  end
                  gpfem_pkg::PH_FALL: begin
                     if (!pin) begin
                        value_in = '0;
                        fall_evt = 1'b1;
                        irq_evt  = conf[3];
                        phase_in = gpfem_pkg::PH_RISE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
      if (ctl.cfg_clear) begin
         phase_in = gpfem_pkg::PH_CHECK;
      end
   end

   assign stat.duty    = duty_in;
   assign stat.value   = value_in;
   assign stat.out_bit = out_in;
   assign stat.busy    = busy_in;
   assign stat.rise    = rise_evt;
   assign stat.fall    = fall_evt;
   assign stat.irq     = irq_evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         value_ff <= '0;
         phase_ff <= gpfem_pkg::PH_CHECK;
         out_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         duty_ff  <= duty_in;
         value_ff <= value_in;
         phase_ff <= phase_in;
         out_ff   <= out_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

`default_nettype wire
